/* src/lfra_pkg.sv */
// Shared constants for the lowest-free resource assigner.
package lfra_pkg;

  // Width of the start and end timestamps of a request.
  localparam int unsigned TimeW = 32;

  // Default size of the resource pool and of the per-resource grant counters.
  localparam int unsigned NumResourcesDef = 64;
  localparam int unsigned CountWidthDef   = 16;

endpackage

/* src/lfra_if.sv */
// Handshake interfaces for the request and grant channels of the assigner.
interface lfra_req_if;
  import lfra_pkg::*;

  logic             valid;
  logic             ready;
  logic [TimeW-1:0] start_time;
  logic [TimeW-1:0] end_time;

  modport source (output valid, output start_time, output end_time, input ready);
  modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

interface lfra_grant_if #(
  parameter int unsigned IdxW = 6,
  parameter int unsigned CntW = 16,
  parameter int unsigned HwW  = 7
);
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] granted_index;
  logic [CntW-1:0] grant_count;
  logic [HwW-1:0]  resources_used;
  logic            full_res;

  modport source (
    output valid, output granted_index, output grant_count,
    output resources_used, output full_res, input ready
  );
  modport sink (
    input valid, input granted_index, input grant_count,
    input resources_used, input full_res, output ready
  );
endinterface

/* src/lfra_pool.sv */
// Busy state of the resource pool: parallel release compares and lowest-free pick.
module lfra_pool import lfra_pkg::*; #(
  parameter int unsigned NumResources = NumResourcesDef,
  localparam int unsigned IdxW = $clog2(NumResources)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [TimeW-1:0] start_time_i,
  input  logic [TimeW-1:0] end_time_i,
  output logic             found_o,
  output logic [IdxW-1:0]  pick_o
);

  logic [NumResources-1:0] busy_q, busy_d, free_vec;
  logic [TimeW-1:0]        busy_until_q [NumResources];

  // A resource is free if it is idle or its reservation ends by the new start.
  always_comb begin
    for (int i = 0; i < NumResources; i++) begin
      free_vec[i] = !busy_q[i] || (busy_until_q[i] <= start_time_i);
    end
  end

  // Lowest-numbered free resource wins.
  always_comb begin
    found_o = 1'b0;
    pick_o  = '0;
    for (int i = NumResources - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found_o = 1'b1;
        pick_o  = IdxW'(i);
      end
    end
  end

  always_comb begin
    busy_d = busy_q & ~free_vec;
    if (found_o) begin
      busy_d[pick_o] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (take_i) begin
      busy_q <= busy_d;
    end
  end

  // End times only matter while the busy bit is set, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (take_i && found_o) begin
      busy_until_q[pick_o] <= end_time_i;
    end
  end

endmodule

/* src/lfra_cnt_mem.sv */
// Grant counter memory with per-entry valid bits and write-to-read bypass.
module lfra_cnt_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // A read of the entry being written this cycle returns the new value.
  // Entries never written read as zero.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else if (vld_q[rd_addr_i]) begin
        rd_data_q <= mem[rd_addr_i];
      end else begin
        rd_data_q <= '0;
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/lowest_free_resource_assigner.sv */
// Top level of the lowest-free resource assigner.
//
// Each request item (start_time, end_time) releases every resource whose
// reservation ends at or before start_time, then grants the lowest-numbered
// free resource until end_time and returns one result item with the granted
// index, that resource's saturating grant count, the number of distinct
// resources ever used and a full flag that is set when every resource is
// still busy. Requests are expected in nondecreasing start order; nothing
// checks it. The block takes one item in every cycle in steady state while
// the grant channel does not stall, and a result passes through these
// registers in order: the request register takes the request, the count
// stage registers take the outcome of the single pass of parallel end-time
// compares and the priority encoder together with the count read from the
// grant counter memory, and the result register takes the incremented count.
// A stall on the grant channel holds the whole pipeline. After reset the
// block is ready at once; counters start at zero through per-entry valid
// bits, with no clearing pass.
module lowest_free_resource_assigner import lfra_pkg::*; #(
  parameter int unsigned NumResources = NumResourcesDef,
  parameter int unsigned CountWidth   = CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfra_req_if.sink    req_i,
  lfra_grant_if.source grant_o
);

  localparam int unsigned IdxW = $clog2(NumResources);
  localparam int unsigned HwW  = $clog2(NumResources + 1);

  // Global stall: nothing moves while the result register waits to be taken.
  logic stall;
  assign stall     = grant_o.valid && !grant_o.ready;
  assign req_i.ready = !stall;

  // Request register.
  logic             s1_vld_q;
  logic [TimeW-1:0] s1_start_q, s1_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (!stall) begin
      s1_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall && req_i.valid) begin
      s1_start_q <= req_i.start_time;
      s1_end_q   <= req_i.end_time;
    end
  end

  // Pick stage: release, lowest-free selection and high-water update.
  logic            take;
  logic            found;
  logic [IdxW-1:0] pick;
  logic [HwW-1:0]  hw_q, hw_d, pick_plus1;

  assign take = s1_vld_q && !stall;

  lfra_pool #(
    .NumResources(NumResources)
  ) u_pool (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .start_time_i(s1_start_q),
    .end_time_i  (s1_end_q),
    .found_o     (found),
    .pick_o      (pick)
  );

  always_comb begin
    pick_plus1 = HwW'(pick) + HwW'(1);
    hw_d       = hw_q;
    if (found && (pick_plus1 > hw_q)) begin
      hw_d = pick_plus1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= '0;
    end else if (take) begin
      hw_q <= hw_d;
    end
  end

  // Count stage registers; the counter memory read lines up with them.
  logic            s2_vld_q;
  logic            s2_found_q;
  logic [IdxW-1:0] s2_pick_q;
  logic [HwW-1:0]  s2_hw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (!stall) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s2_found_q <= found;
      s2_pick_q  <= pick;
      s2_hw_q    <= hw_d;
    end
  end

  logic [CountWidth-1:0] cnt_rd, cnt_inc;
  logic                  cnt_wr;

  assign cnt_inc = (cnt_rd == '1) ? cnt_rd : cnt_rd + CountWidth'(1);
  assign cnt_wr  = s2_vld_q && s2_found_q && !stall;

  lfra_cnt_mem #(
    .Depth(NumResources),
    .Width(CountWidth)
  ) u_cnt_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (take),
    .rd_addr_i(pick),
    .rd_data_o(cnt_rd),
    .wr_en_i  (cnt_wr),
    .wr_addr_i(s2_pick_q),
    .wr_data_i(cnt_inc)
  );

  // Result register.
  logic                  out_vld_q;
  logic [IdxW-1:0]       out_idx_q;
  logic [CountWidth-1:0] out_cnt_q;
  logic [HwW-1:0]        out_hw_q;
  logic                  out_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!stall) begin
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall && s2_vld_q) begin
      out_idx_q  <= s2_found_q ? s2_pick_q : '0;
      out_cnt_q  <= s2_found_q ? cnt_inc : '0;
      out_hw_q   <= s2_hw_q;
      out_full_q <= !s2_found_q;
    end
  end

  assign grant_o.valid          = out_vld_q;
  assign grant_o.granted_index  = out_idx_q;
  assign grant_o.grant_count    = out_cnt_q;
  assign grant_o.resources_used = out_hw_q;
  assign grant_o.full_res       = out_full_q;

  // The high-water mark never drops.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q >= $past(hw_q))
    else $error("high-water mark decreased");

  // A granted resource always lies below the reported high-water mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grant_o.valid && !grant_o.full_res) |->
      (HwW'(grant_o.granted_index) < grant_o.resources_used))
    else $error("granted index at or above resources_used");

  // A grant always counts at least itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grant_o.valid && !grant_o.full_res) |-> (grant_o.grant_count != '0))
    else $error("grant with zero count");

endmodule
